@@ design/kmh_pkg.sv @@
// Shared types, constants and compare function of the k-way posting merge.
`timescale 1ns / 1ps
package kmh_pkg;

    localparam int MaxWays = 128;
    localparam int WayW    = $clog2(MaxWays);
    localparam int KeyW    = 31;
    localparam int CntW    = WayW + 1;
    localparam int NodeW   = WayW + 2;
    localparam int CfgW    = 8;

    typedef enum logic [0:0] {
        OP_REC = 1'b0,
        OP_END = 1'b1
    } t_op;

    typedef struct packed {
        logic [KeyW-1:0] word;
        logic [KeyW-1:0] doc;
        logic [KeyW-1:0] freq;
    } t_rec;

    localparam int RecW = $bits(t_rec);

    typedef struct packed {
        t_op  op;
        t_rec rec;
    } t_item;

    // word first, then document; ties are not less
    function automatic logic rec_less(input t_rec a, input t_rec b);
        logic res;
        if (a.word != b.word) begin
            res = (a.word < b.word);
        end else begin
            res = (a.doc < b.doc);
        end
        return res;
    endfunction

endpackage

@@ design/kmh_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module kmh_ram #(
    parameter int W = 8,
    parameter int D = 16
) (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic [$clog2(D)-1:0] i_waddr,
    input  logic [W-1:0]         i_wdata,
    input  logic [$clog2(D)-1:0] i_raddr,
    output logic [W-1:0]         o_rdata
);

    logic [W-1:0] r_mem [D];
    logic [W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ design/kmh_front.sv @@
// Front end: takes input beats and holds them in a two-entry queue.
`timescale 1ns / 1ps
module kmh_front
    import kmh_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  logic            i_op,
    input  logic [KeyW-1:0] i_word_id,
    input  logic [KeyW-1:0] i_doc_id,
    input  logic [KeyW-1:0] i_term_freq,
    output logic            o_q_valid,
    output t_item           o_q_item,
    input  logic            i_q_pop
);

    t_item       r_slot [2];
    logic        r_wp, n_wp;
    logic        r_rp, n_rp;
    logic [1:0]  r_fill, n_fill;
    logic        push;
    t_item       item;

    // classify the beat into an operation and a record
    always_comb begin
        item.op       = (i_op == 1'b1) ? OP_END : OP_REC;
        item.rec.word = i_word_id;
        item.rec.doc  = i_doc_id;
        item.rec.freq = i_term_freq;
    end

    assign o_in_ready = (r_fill != 2'd2);
    assign push       = i_in_valid && o_in_ready;
    assign o_q_valid  = (r_fill != 2'd0);
    assign o_q_item   = r_slot[r_rp];

    always_comb begin
        n_wp   = r_wp ^ push;
        n_rp   = r_rp ^ i_q_pop;
        n_fill = r_fill + {1'b0, push} - {1'b0, i_q_pop};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp   <= 1'b0;
            r_rp   <= 1'b0;
            r_fill <= 2'd0;
        end else begin
            r_wp   <= n_wp;
            r_rp   <= n_rp;
            r_fill <= n_fill;
        end
    end

    // queue payload
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_slot[r_wp] <= item;
        end
    end

endmodule

@@ design/kmh_back.sv @@
// Back end: head store, heap store, fill/build/sift sequencer and result register.
`timescale 1ns / 1ps
module kmh_back
    import kmh_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic [CfgW-1:0] i_num_ways,
    input  logic            i_q_valid,
    input  t_item           i_q_item,
    output logic            o_q_pop,
    output logic            o_res_valid,
    input  logic            i_res_ready,
    output logic            o_out_valid,
    output logic [KeyW-1:0] o_out_word,
    output logic [KeyW-1:0] o_out_doc,
    output logic [KeyW-1:0] o_out_freq,
    output logic [WayW-1:0] o_source_way,
    output logic            o_last
);

    typedef enum logic [12:0] {
        ST_IDLE = 13'b0000000000001,
        ST_LD_A = 13'b0000000000010,
        ST_LD_B = 13'b0000000000100,
        ST_LD_C = 13'b0000000001000,
        ST_RD_L = 13'b0000000010000,
        ST_RD_R = 13'b0000000100000,
        ST_RD_H = 13'b0000001000000,
        ST_CMP  = 13'b0000010000000,
        ST_END  = 13'b0000100000000,
        ST_EM_A = 13'b0001000000000,
        ST_EM_B = 13'b0010000000000,
        ST_EM_C = 13'b0100000000000,
        ST_EM_E = 13'b1000000000000
    } t_state;

    t_state          r_state, n_state;
    logic [CntW-1:0] r_cnt, n_cnt;
    logic [CntW-1:0] r_fill, n_fill;
    logic            r_merging, n_merging;
    logic            r_build, n_build;
    logic [CntW-1:0] r_node, n_node;
    logic [CntW-1:0] r_bnode, n_bnode;
    logic [WayW-1:0] r_ld_addr, n_ld_addr;
    logic [WayW-1:0] r_cw, n_cw;
    t_rec            r_cr, n_cr;
    logic [WayW-1:0] r_lway, n_lway;
    logic [WayW-1:0] r_rway, n_rway;
    t_rec            r_lrec, n_lrec;
    logic [WayW-1:0] r_root, n_root;

    logic            r_o_vld;
    logic            r_o_valid;
    t_rec            r_o_rec;
    logic [WayW-1:0] r_o_way;
    logic            r_o_last;
    logic            load_res, res_empty;
    logic            slot_free;

    // RAM ports
    logic            head_we, heap_we;
    logic [WayW-1:0] head_waddr, heap_waddr, head_raddr, heap_raddr;
    t_rec            head_wdata;
    logic [WayW-1:0] heap_wdata, heap_rdata;
    logic [RecW-1:0] head_rdata_raw;
    t_rec            head_rdata;

    // datapath helpers
    logic [CfgW-1:0]  nw;
    logic [CntW-1:0]  cnt0, cnt_inc, fill_inc;
    logic [NodeW-1:0] lnode, rnode;
    logic             r_ok, l_win, r_win;
    t_rec             brec;

    kmh_ram #(.W(RecW), .D(MaxWays)) u_head (
        .i_clk   (i_clk),
        .i_we    (head_we),
        .i_waddr (head_waddr),
        .i_wdata (head_wdata),
        .i_raddr (head_raddr),
        .o_rdata (head_rdata_raw)
    );

    kmh_ram #(.W(WayW), .D(MaxWays)) u_heap (
        .i_clk   (i_clk),
        .i_we    (heap_we),
        .i_waddr (heap_waddr),
        .i_wdata (heap_wdata),
        .i_raddr (heap_raddr),
        .o_rdata (heap_rdata)
    );

    assign head_rdata = t_rec'(head_rdata_raw);
    assign slot_free  = !r_o_vld || i_res_ready;

    // clamp the way count to 1..MaxWays
    always_comb begin
        if (i_num_ways == '0) begin
            nw = CfgW'(1);
        end else if (i_num_ways > CfgW'(MaxWays)) begin
            nw = CfgW'(MaxWays);
        end else begin
            nw = i_num_ways;
        end
    end

    assign cnt0     = (r_fill == '0) ? '0 : r_cnt;
    assign cnt_inc  = cnt0 + CntW'(1);
    assign fill_inc = r_fill + CntW'(1);
    assign lnode    = {r_node, 1'b0};
    assign rnode    = lnode + NodeW'(1);
    assign r_ok     = (rnode <= NodeW'(r_cnt));
    assign l_win    = rec_less(r_lrec, r_cr);
    assign brec     = l_win ? r_lrec : r_cr;
    assign r_win    = r_ok && rec_less(head_rdata, brec);

    // sequencer
    always_comb begin
        n_state   = r_state;
        n_cnt     = r_cnt;
        n_fill    = r_fill;
        n_merging = r_merging;
        n_build   = r_build;
        n_node    = r_node;
        n_bnode   = r_bnode;
        n_ld_addr = r_ld_addr;
        n_cw      = r_cw;
        n_cr      = r_cr;
        n_lway    = r_lway;
        n_rway    = r_rway;
        n_lrec    = r_lrec;
        n_root    = r_root;
        o_q_pop   = 1'b0;
        head_we    = 1'b0;
        head_waddr = r_fill[WayW-1:0];
        head_wdata = i_q_item.rec;
        head_raddr = r_root;
        heap_we    = 1'b0;
        heap_waddr = cnt0[WayW-1:0];
        heap_wdata = r_fill[WayW-1:0];
        heap_raddr = '0;
        load_res   = 1'b0;
        res_empty  = 1'b0;

        unique case (r_state)
            ST_IDLE: begin
                if (i_q_valid) begin
                    o_q_pop = 1'b1;
                    if (!r_merging) begin
                        // fill step for way r_fill
                        n_cnt = cnt0;
                        if (i_q_item.op == OP_REC) begin
                            head_we = 1'b1;
                            heap_we = 1'b1;
                            n_cnt   = cnt_inc;
                        end
                        n_fill = fill_inc;
                        if (fill_inc >= CntW'(nw)) begin
                            n_merging = 1'b1;
                            n_bnode   = n_cnt >> 1;
                            if (n_cnt == '0) begin
                                n_state = ST_EM_E;
                            end else if ((n_cnt >> 1) == '0) begin
                                n_state = ST_EM_A;
                            end else begin
                                n_build   = 1'b1;
                                n_node    = n_cnt >> 1;
                                n_ld_addr = WayW'((n_cnt >> 1) - CntW'(1));
                                n_state   = ST_LD_A;
                            end
                        end
                    end else if (r_cnt == '0) begin
                        n_state = ST_EM_E;
                    end else if (i_q_item.op == OP_REC) begin
                        // new head for the root way
                        head_we    = 1'b1;
                        head_waddr = r_root;
                        n_cw       = r_root;
                        n_cr       = i_q_item.rec;
                        n_node     = CntW'(1);
                        n_build    = 1'b0;
                        n_state    = ST_RD_L;
                    end else begin
                        // last entry moves to the root
                        n_cnt = r_cnt - CntW'(1);
                        if (r_cnt == CntW'(1)) begin
                            n_state = ST_EM_E;
                        end else begin
                            n_ld_addr = WayW'(r_cnt - CntW'(1));
                            n_node    = CntW'(1);
                            n_build   = 1'b0;
                            n_state   = ST_LD_A;
                        end
                    end
                end
            end
            ST_LD_A: begin
                heap_raddr = r_ld_addr;
                n_state    = ST_LD_B;
            end
            ST_LD_B: begin
                n_cw       = heap_rdata;
                head_raddr = heap_rdata;
                n_state    = ST_LD_C;
            end
            ST_LD_C: begin
                n_cr    = head_rdata;
                n_state = ST_RD_L;
            end
            ST_RD_L: begin
                heap_raddr = WayW'(lnode - NodeW'(1));
                if (lnode > NodeW'(r_cnt)) begin
                    n_state = ST_END;
                end else begin
                    n_state = ST_RD_R;
                end
            end
            ST_RD_R: begin
                heap_raddr = lnode[WayW-1:0];
                n_lway     = heap_rdata;
                head_raddr = heap_rdata;
                n_state    = ST_RD_H;
            end
            ST_RD_H: begin
                n_rway     = heap_rdata;
                head_raddr = heap_rdata;
                n_lrec     = head_rdata;
                n_state    = ST_CMP;
            end
            ST_CMP: begin
                // strictly smaller child moves up
                if (!l_win && !r_win) begin
                    n_state = ST_END;
                end else begin
                    heap_we    = 1'b1;
                    heap_waddr = WayW'(r_node - CntW'(1));
                    heap_wdata = r_win ? r_rway : r_lway;
                    n_node     = r_win ? CntW'(rnode) : CntW'(lnode);
                    n_state    = ST_RD_L;
                end
            end
            ST_END: begin
                heap_we    = 1'b1;
                heap_waddr = WayW'(r_node - CntW'(1));
                heap_wdata = r_cw;
                if (r_build && (r_bnode > CntW'(1))) begin
                    n_bnode   = r_bnode - CntW'(1);
                    n_node    = r_bnode - CntW'(1);
                    n_ld_addr = WayW'(r_bnode - CntW'(2));
                    n_state   = ST_LD_A;
                end else begin
                    n_build = 1'b0;
                    n_state = ST_EM_A;
                end
            end
            ST_EM_A: begin
                heap_raddr = '0;
                n_state    = ST_EM_B;
            end
            ST_EM_B: begin
                n_root     = heap_rdata;
                head_raddr = heap_rdata;
                n_state    = ST_EM_C;
            end
            ST_EM_C: begin
                head_raddr = r_root;
                if (slot_free) begin
                    load_res = 1'b1;
                    n_state  = ST_IDLE;
                end
            end
            ST_EM_E: begin
                if (slot_free) begin
                    load_res  = 1'b1;
                    res_empty = 1'b1;
                    n_merging = 1'b0;
                    n_fill    = '0;
                    n_state   = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_cnt     <= '0;
            r_fill    <= '0;
            r_merging <= 1'b0;
            r_build   <= 1'b0;
            r_o_vld   <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_cnt     <= n_cnt;
            r_fill    <= n_fill;
            r_merging <= n_merging;
            r_build   <= n_build;
            if (load_res) begin
                r_o_vld <= 1'b1;
            end else if (i_res_ready) begin
                r_o_vld <= 1'b0;
            end
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        r_node    <= n_node;
        r_bnode   <= n_bnode;
        r_ld_addr <= n_ld_addr;
        r_cw      <= n_cw;
        r_cr      <= n_cr;
        r_lway    <= n_lway;
        r_rway    <= n_rway;
        r_lrec    <= n_lrec;
        r_root    <= n_root;
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (load_res) begin
            r_o_valid <= !res_empty;
            r_o_last  <= res_empty;
            r_o_rec   <= res_empty ? '0 : head_rdata;
            r_o_way   <= res_empty ? '0 : r_root;
        end
    end

    assign o_res_valid  = r_o_vld;
    assign o_out_valid  = r_o_valid;
    assign o_out_word   = r_o_rec.word;
    assign o_out_doc    = r_o_rec.doc;
    assign o_out_freq   = r_o_rec.freq;
    assign o_source_way = r_o_way;
    assign o_last       = r_o_last;

endmodule

@@ design/kway_posting_merge_heap_core.sv @@
// K-way posting merge: a beat waits in the queue, then a fill beat is taken in idle.
// A merge record beat writes the root head and sifts it down, up to 7 levels, each a
// read of children, a head read and a compare; an end mark first moves the last entry up.
// The last fill beat adds the heap build, one sift-down per inner node.
// Synchronous active-low reset clears control state and the way count to 2;
// RAM contents are not cleared.
`timescale 1ns / 1ps
module kway_posting_merge_heap_core
    import kmh_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_cfg_valid,
    output logic            o_cfg_ready,
    input  logic [CfgW-1:0] i_cfg_data,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  logic            i_op,
    input  logic [WayW-1:0] i_way,
    input  logic [KeyW-1:0] i_word_id,
    input  logic [KeyW-1:0] i_doc_id,
    input  logic [KeyW-1:0] i_term_freq,
    output logic            o_res_valid,
    input  logic            i_res_ready,
    output logic            o_out_valid,
    output logic [KeyW-1:0] o_out_word,
    output logic [KeyW-1:0] o_out_doc,
    output logic [KeyW-1:0] o_out_freq,
    output logic [WayW-1:0] o_source_way,
    output logic            o_last
);

    logic [CfgW-1:0] r_num_ways;
    logic            q_valid, q_pop;
    t_item           q_item;

    // way count register; the way field is informative only
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_ways <= CfgW'(2);
        end else if (i_cfg_valid) begin
            r_num_ways <= i_cfg_data;
        end
    end

    kmh_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_op        (i_op),
        .i_word_id   (i_word_id),
        .i_doc_id    (i_doc_id),
        .i_term_freq (i_term_freq),
        .o_q_valid   (q_valid),
        .o_q_item    (q_item),
        .i_q_pop     (q_pop)
    );

    kmh_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_num_ways   (r_num_ways),
        .i_q_valid    (q_valid),
        .i_q_item     (q_item),
        .o_q_pop      (q_pop),
        .o_res_valid  (o_res_valid),
        .i_res_ready  (i_res_ready),
        .o_out_valid  (o_out_valid),
        .o_out_word   (o_out_word),
        .o_out_doc    (o_out_doc),
        .o_out_freq   (o_out_freq),
        .o_source_way (o_source_way),
        .o_last       (o_last)
    );

endmodule

@@ tb/kway_posting_merge_heap_core_test.sv @@
// Testbench for the k-way posting merge heap: directed and random merge groups.
`timescale 1ns / 1ps
module kway_posting_merge_heap_core_test;
    import kmh_pkg::*;

    // Predicted merge output, one per beat that produces a result
    typedef struct {
        logic            valid;
        logic [KeyW-1:0] word;
        logic [KeyW-1:0] doc;
        logic [KeyW-1:0] freq;
        logic [WayW-1:0] way;
        logic            last;
    } t_merge_out;

    // Scoreboard: its own heap model and a queue of pending merge outputs
    class merge_scoreboard;
        t_rec             heads[MaxWays];
        logic [WayW-1:0]  order[MaxWays + 1];
        int               heap_size;
        int               filled;
        bit               in_merge;
        int               way_count;
        t_merge_out       pending[$];
        int               mismatches;

        function void clear();
            heap_size = 0;
            filled    = 0;
            in_merge  = 0;
            way_count = 2;
            mismatches = 0;
            pending.delete();
        endfunction

        function bit smaller(int a, int b);
            t_rec x;
            t_rec y;
            x = heads[order[a]];
            y = heads[order[b]];
            if (x.word != y.word) return x.word < y.word;
            return x.doc < y.doc;
        endfunction

        function void sift(int node);
            int best;
            int l;
            logic [WayW-1:0] t;
            forever begin
                best = node;
                l = node * 2;
                if (l <= heap_size && smaller(l, best)) best = l;
                if (l + 1 <= heap_size && smaller(l + 1, best)) best = l + 1;
                if (best == node) break;
                t = order[node];
                order[node] = order[best];
                order[best] = t;
                node = best;
            end
        endfunction

        function void push_min();
            t_merge_out o;
            if (heap_size == 0) begin
                o = '{1'b0, '0, '0, '0, '0, 1'b1};
                in_merge = 0;
                filled = 0;
            end else begin
                o.valid = 1'b1;
                o.word  = heads[order[1]].word;
                o.doc   = heads[order[1]].doc;
                o.freq  = heads[order[1]].freq;
                o.way   = order[1];
                o.last  = 1'b0;
            end
            pending.push_back(o);
        endfunction

        function void note_input(t_op op, t_rec r);
            int n;
            if (!in_merge) begin
                n = way_count;
                if (n == 0) n = 1;
                if (n > MaxWays) n = MaxWays;
                if (filled == 0) heap_size = 0;
                if (filled < MaxWays && op == OP_REC) begin
                    heads[filled] = r;
                    heap_size++;
                    order[heap_size] = WayW'(filled);
                end
                filled++;
                if (filled < n) return;
                for (int i = heap_size / 2; i > 0; i--) sift(i);
                in_merge = 1;
                push_min();
                return;
            end
            if (heap_size == 0) begin
                push_min();
                return;
            end
            if (op == OP_REC) begin
                heads[order[1]] = r;
            end else begin
                order[1] = order[heap_size];
                heap_size--;
            end
            if (heap_size > 1) sift(1);
            push_min();
        endfunction

        function void check_result(t_merge_out got);
            t_merge_out exp;
            if (pending.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result beat at %0t", $realtime);
                return;
            end
            exp = pending.pop_front();
            if (got.valid !== exp.valid || got.word !== exp.word || got.doc !== exp.doc
                || got.freq !== exp.freq || got.way !== exp.way || got.last !== exp.last) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: exp v%0b w%0h d%0h f%0h way%0d l%0b, got v%0b w%0h d%0h f%0h way%0d l%0b",
                        exp.valid, exp.word, exp.doc, exp.freq, exp.way, exp.last,
                        got.valid, got.word, got.doc, got.freq, got.way, got.last);
            end
        endfunction
    endclass

    logic            clk = 0;
    logic            rst_n = 0;
    logic            cfg_valid = 0;
    logic            cfg_ready;
    logic [CfgW-1:0] cfg_data = '0;
    logic            in_valid = 0;
    logic            in_ready;
    logic            op = 0;
    logic [WayW-1:0] way_in = '0;
    logic [KeyW-1:0] word_in = '0;
    logic [KeyW-1:0] doc_in = '0;
    logic [KeyW-1:0] freq_in = '0;
    logic            res_valid;
    logic            res_ready = 0;
    logic            out_valid;
    logic [KeyW-1:0] out_word;
    logic [KeyW-1:0] out_doc;
    logic [KeyW-1:0] out_freq;
    logic [WayW-1:0] source_way;
    logic            last;

    merge_scoreboard sb;
    int              cycles = 0;
    bit              hold_off = 0;
    int              sent = 0;

    kway_posting_merge_heap_core dut (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_cfg_valid(cfg_valid), .o_cfg_ready(cfg_ready), .i_cfg_data(cfg_data),
        .i_in_valid(in_valid), .o_in_ready(in_ready), .i_op(op), .i_way(way_in),
        .i_word_id(word_in), .i_doc_id(doc_in), .i_term_freq(freq_in),
        .o_res_valid(res_valid), .i_res_ready(res_ready), .o_out_valid(out_valid),
        .o_out_word(out_word), .o_out_doc(out_doc), .o_out_freq(out_freq),
        .o_source_way(source_way), .o_last(last)
    );

    initial begin
        forever #6 clk = ~clk;
    end

    // Watchdog
    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles > 2000000) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Result side: sample accepted beats, stall on its own pattern
    always @(posedge clk) begin
        t_merge_out got;
        if (rst_n && res_valid && res_ready) begin
            got = '{out_valid, out_word, out_doc, out_freq, source_way, last};
            sb.check_result(got);
        end
        if (hold_off) res_ready <= 1'b0;
        else if (cycles % 64 < 40) res_ready <= 1'b1;
        else res_ready <= ($urandom_range(3) != 0);
    end

    // One beat into the block; payload held until accepted, valid left high
    task automatic send_beat(t_op o, logic [KeyW-1:0] w, logic [KeyW-1:0] d,
                             logic [KeyW-1:0] f);
        in_valid <= 1'b1;
        op       <= o;
        way_in   <= WayW'($urandom);
        word_in  <= w;
        doc_in   <= d;
        freq_in  <= f;
        do @(posedge clk); while (!in_ready);
        sb.note_input(o, '{w, d, f});
        sent++;
    endtask

    // Drop valid before the sender waits
    task automatic sender_idle();
        in_valid <= 1'b0;
    endtask

    task automatic sender_gap();
        if ($urandom_range(7) == 0) begin
            sender_idle();
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
    endtask

    // Register write while idle
    task automatic set_ways(logic [CfgW-1:0] n);
        cfg_valid <= 1'b1;
        cfg_data  <= n;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        sb.way_count = int'(n);
    endtask

    task automatic drain();
        sender_idle();
        while (sb.pending.size() != 0) @(posedge clk);
        repeat (200) @(posedge clk);
    endtask

    // One group: each way a sorted run of random length up to max_len (0 = empty way)
    task automatic run_group(int ways, int max_len, bit noisy);
        int runs[MaxWays];
        int pos[MaxWays];
        logic [KeyW-1:0] last_w[MaxWays];
        logic [KeyW-1:0] w;
        int n;
        n = (ways == 0) ? 1 : (ways > MaxWays ? MaxWays : ways);
        for (int i = 0; i < n; i++) begin
            runs[i] = $urandom_range(max_len);
            pos[i] = 0;
            last_w[i] = KeyW'($urandom_range(50));
            if (runs[i] == 0)
                send_beat(OP_END, KeyW'($urandom), KeyW'($urandom), KeyW'($urandom));
            else
                send_beat(OP_REC, last_w[i], KeyW'($urandom_range(3)), KeyW'($urandom));
            if (runs[i] != 0) pos[i] = 1;
            sender_gap();
        end
        while (sb.in_merge) begin
            int k;
            k = int'(sb.order[1]);
            if (noisy && $urandom_range(9) == 0) begin
                send_beat(t_op'($urandom_range(1)), KeyW'($urandom), KeyW'($urandom),
                          KeyW'($urandom));
            end else if (pos[k] < runs[k]) begin
                w = last_w[k] + KeyW'($urandom_range(2));
                last_w[k] = w;
                send_beat(OP_REC, w, KeyW'($urandom_range(5)), KeyW'($urandom));
                pos[k]++;
            end else begin
                send_beat(OP_END, KeyW'($urandom), KeyW'($urandom), KeyW'($urandom));
            end
            sender_gap();
        end
    endtask

    initial begin
        sb = new();
        sb.clear();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: extremes of keys with the reset way count of two
        send_beat(OP_REC, '1, '1, '1);
        send_beat(OP_REC, '0, '0, '0);
        send_beat(OP_REC, '1, '0, '1);
        send_beat(OP_REC, '0, '1, '0);
        send_beat(OP_END, '0, '0, '0);
        send_beat(OP_END, '0, '0, '0);
        send_beat(OP_END, '0, '0, '0);
        // ties between ways keep the parent
        send_beat(OP_REC, 31'd5, 31'd5, 31'd1);
        send_beat(OP_REC, 31'd5, 31'd5, 31'd2);
        send_beat(OP_END, '0, '0, '0);
        send_beat(OP_END, '0, '0, '0);
        drain();
        // every way empty, then way count of zero acting as one
        send_beat(OP_END, '0, '0, '0);
        send_beat(OP_END, '0, '0, '0);
        drain();
        set_ways(8'd0);
        send_beat(OP_REC, 31'h2aaaaaaa, 31'h55555555, 31'h12345678);
        send_beat(OP_END, '0, '0, '0);
        drain();
        // above the maximum acts as the maximum
        set_ways(8'd255);
        run_group(255, 1, 0);
        drain();
        // long receiver stall once merging starts, so the block fills up
        set_ways(8'd128);
        fork
            begin
                while (!sb.in_merge) @(posedge clk);
                hold_off = 1;
                repeat (400) @(posedge clk);
                hold_off = 0;
            end
        join_none
        run_group(128, 2, 0);
        drain();

        // Random groups with assorted way counts
        while (sent < 900) begin
            int n;
            n = ($urandom_range(9) == 0) ? $urandom_range(20, 128) : $urandom_range(1, 8);
            set_ways(n[CfgW-1:0]);
            run_group(n, $urandom_range(1, 6), 1);
            drain();
        end

        drain();
        if (sb.mismatches == 0 && sb.pending.size() == 0) $display("*** PASSED ***");
        else $display("*** FAILED ***");
        $finish;
    end
endmodule
